/* sv/lruc_pkg.sv */
// Package with shared constants, operation codes and the controller command type.
package lruc_pkg;

  // Default sizes of the store and of the payload fields.
  localparam int ENTRIES_DEF    = 16;
  localparam int VALUE_BITS_DEF = 64;
  localparam int KEY_BITS_DEF   = 31;

  // Capacity register width and its value after reset.
  localparam int             CAP_BITS  = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // Operation codes carried in the mode field.
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;  // capture an accepted input transaction
    logic match;    // compare the key and plan the update
    logic update;   // apply the update and load the result register
    logic clear;    // capacity write: empty the store
  } lruc_cmd_t;

endpackage

/* sv/lruc_ifs.sv */
// Channel interfaces for the input, result and configuration transactions.
interface lruc_in_if import lruc_pkg::*; #(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] write_value;

  modport source (output valid, mode, key, write_value, input ready);
  modport sink   (input valid, mode, key, write_value, output ready);
endinterface

interface lruc_out_if import lruc_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lruc_cfg_if import lruc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CAP_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* sv/lru_key_value_cache_core.sv */
// Top level of the fully associative key-value cache with LRU replacement.
// Each accepted transaction passes through a match cycle, which compares the key against
// every entry in parallel and reads the value memory, and an update cycle, which ages the
// entries, writes the memory and loads the result register. A new transaction is accepted
// in that update cycle, so back-to-back transactions overlap as long as results are taken;
// the result register holds a finished result while the next transaction is captured.
// A capacity write empties the store at once (no clearing pass) and is taken only while
// no transaction is in flight. Values above the store size act as the store size, and zero
// keeps nothing.
module lru_key_value_cache_core import lruc_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  lruc_in_if.sink    in_ch,
  lruc_out_if.source out_ch,
  lruc_cfg_if.sink   cfg_ch
);

  lruc_cmd_t cmd;

  lruc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  lruc_dp #(
    .ENTRIES    (ENTRIES),
    .VALUE_BITS (VALUE_BITS),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_mode        (in_ch.mode),
    .in_key         (in_ch.key),
    .in_write_value (in_ch.write_value),
    .cfg_data       (cfg_ch.data),
    .out_hit        (out_ch.hit),
    .out_read_value (out_ch.read_value)
  );

endmodule

/* sv/lruc_ctrl.sv */
// Controller state machine that sequences lookup, update and result hand-off.
module lruc_ctrl import lruc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output lruc_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MATCH  = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       in_acc;
  logic       upd_go;

  // The result register can take a new result when empty or being drained.
  assign out_free  = !out_valid_r || out_ready;
  assign upd_go    = (state_r == S_UPDATE) && out_free;
  assign in_ready  = (state_r == S_IDLE) || upd_go;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Commands to the datapath.
  always_comb begin
    cmd.load_in = in_acc;
    cmd.match   = (state_r == S_MATCH);
    cmd.update  = upd_go;
    cmd.clear   = cfg_valid && cfg_ready;
  end

  // Next state and result-valid logic.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (upd_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = in_acc ? S_MATCH : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/lruc_dp.sv */
// Datapath with the key match, age ranks, value memory and result register.
module lruc_dp import lruc_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lruc_cmd_t             cmd,
  input  logic                  in_mode,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_write_value,
  input  logic [CAP_BITS-1:0]   cfg_data,
  output logic                  out_hit,
  output logic [VALUE_BITS-1:0] out_read_value
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // Input transaction registers.
  logic                  mode_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;

  // Entry state: valid bits, keys and age ranks in flops, values in memory.
  logic [ENTRIES-1:0]    valid_r;
  logic [KEY_BITS-1:0]   key_arr_r [ENTRIES];
  logic [IW-1:0]         age_r     [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem   [ENTRIES];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic [CW-1:0]         count_r;
  logic [CAP_BITS-1:0]   cap_r;

  // Plan registered at the end of the match cycle.
  logic          hit_r, hit_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic [CW-1:0] limit_r, limit_nxt;
  logic          promote_r, promote_nxt;
  logic          wr_val_r, wr_val_nxt;
  logic          set_key_r, set_key_nxt;
  logic          insert_r, insert_nxt;

  // Result register.
  logic                  out_hit_r;
  logic [VALUE_BITS-1:0] out_read_value_r;

  logic [ENTRIES-1:0] match;
  logic [IW-1:0]      found_idx;
  logic [IW-1:0]      found_age;
  logic [IW-1:0]      victim_idx;
  logic [IW-1:0]      free_idx;
  logic [CW-1:0]      eff_cap;
  logic [CW-1:0]      count_m1;

  // Capacity above the store size saturates to the store size.
  assign eff_cap  = (32'(cap_r) > ENTRIES) ? CW'(ENTRIES) : CW'(cap_r);
  assign count_m1 = count_r - 1'b1;

  // Parallel key compare against every valid entry.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_arr_r[i] == key_r);
    end
  end

  // Encode the hit slot, its age, the least recent slot and the first free slot.
  always_comb begin
    found_idx  = '0;
    found_age  = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        found_idx = IW'(i);
      end
      found_age = found_age | (match[i] ? age_r[i] : '0);
      if (valid_r[i] && (CW'(age_r[i]) == count_m1)) begin
        victim_idx = IW'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  // Decide what the transaction does to the store.
  always_comb begin
    hit_nxt     = |match;
    slot_nxt    = found_idx;
    limit_nxt   = CW'(found_age);
    promote_nxt = 1'b0;
    wr_val_nxt  = 1'b0;
    set_key_nxt = 1'b0;
    insert_nxt  = 1'b0;
    if (|match) begin
      promote_nxt = 1'b1;
      wr_val_nxt  = (mode_r == MODE_PUT);
    end else if ((mode_r == MODE_PUT) && (eff_cap != '0)) begin
      promote_nxt = 1'b1;
      wr_val_nxt  = 1'b1;
      set_key_nxt = 1'b1;
      if (count_r >= eff_cap) begin
        // Full store: the least recent entry is replaced in place.
        slot_nxt  = victim_idx;
        limit_nxt = count_m1;
      end else begin
        slot_nxt   = free_idx;
        limit_nxt  = count_r;
        insert_nxt = 1'b1;
      end
    end
  end

  // Input capture, plan registers and value memory.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_mode;
      key_r  <= in_key;
      val_r  <= in_write_value;
    end
    if (cmd.match) begin
      hit_r     <= hit_nxt;
      slot_r    <= slot_nxt;
      limit_r   <= limit_nxt;
      promote_r <= promote_nxt;
      wr_val_r  <= wr_val_nxt;
      set_key_r <= set_key_nxt;
      insert_r  <= insert_nxt;
      rd_data_r <= val_mem[found_idx];
    end
    if (cmd.update && wr_val_r) begin
      val_mem[slot_r] <= val_r;
    end
  end

  // Keys and age ranks; an unwritten entry is never read.
  always_ff @(posedge clk) begin
    if (cmd.update && promote_r) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (IW'(i) == slot_r) begin
          age_r[i] <= '0;
          if (set_key_r) begin
            key_arr_r[i] <= key_r;
          end
        end else if (valid_r[i] && (CW'(age_r[i]) < limit_r)) begin
          age_r[i] <= age_r[i] + 1'b1;
        end
      end
    end
  end

  // Valid bits, fill count and capacity.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      cap_r   <= CAP_RESET;
    end else if (cmd.clear) begin
      valid_r <= '0;
      count_r <= '0;
      cap_r   <= cfg_data;
    end else if (cmd.update && insert_r) begin
      valid_r[slot_r] <= 1'b1;
      count_r         <= count_r + 1'b1;
    end
  end

  // Result register: the value is returned only on a get that hits.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r        <= hit_r;
      out_read_value_r <= (hit_r && (mode_r == MODE_GET)) ? rd_data_r : '0;
    end
  end

  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_value_r;

endmodule

/* tb/sv/lruc_answer_checker.sv */
// Checker for the LRU key-value cache: predicts every answer and compares it with the block.
module lruc_answer_checker import lruc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      in_mode,
  input  logic [KEY_BITS_DEF-1:0]   in_key,
  input  logic [VALUE_BITS_DEF-1:0] in_write_value,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      out_hit,
  input  logic [VALUE_BITS_DEF-1:0] out_read_value,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CAP_BITS-1:0]       cfg_data,
  output int                        bad_answers,
  output int                        awaited
);

  typedef struct packed {
    logic                      hit;
    logic [VALUE_BITS_DEF-1:0] read_value;
  } answer_t;

  // Predicted contents of the store, kept in the same LRU order as the block.
  logic                      slot_valid [ENTRIES_DEF];
  logic [KEY_BITS_DEF-1:0]   slot_key   [ENTRIES_DEF];
  logic [VALUE_BITS_DEF-1:0] slot_value [ENTRIES_DEF];
  int                        slot_age   [ENTRIES_DEF];
  int                        slot_count;
  logic [CAP_BITS-1:0]       capacity_q;

  answer_t awaited_answers [$];

  initial begin
    bad_answers = 0;
    awaited     = 0;
  end

  // Empty the store, as after reset or a capacity write.
  function automatic void empty_store();
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_age[i]   = 0;
    end
    slot_count = 0;
  endfunction

  // Make one slot the most recent; valid slots younger than the limit get one step older.
  function automatic void make_most_recent(int s, int limit);
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      if (slot_valid[i] && i != s && slot_age[i] < limit) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  // Apply one access to the predicted store and return the answer it should produce.
  function automatic answer_t cache_access(logic mode, logic [KEY_BITS_DEF-1:0] key,
                                           logic [VALUE_BITS_DEF-1:0] value);
    answer_t ans;
    int      found;
    int      victim;
    int      limit_entries;
    ans.hit        = 1'b0;
    ans.read_value = '0;
    found          = -1;
    victim         = -1;
    limit_entries  = (int'(capacity_q) > ENTRIES_DEF) ? ENTRIES_DEF : int'(capacity_q);
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      if (slot_valid[i] && slot_key[i] == key) found = i;
    end
    // A stored key: read or overwrite, then promote.
    if (found >= 0) begin
      ans.hit = 1'b1;
      if (mode == MODE_GET) ans.read_value = slot_value[found];
      else slot_value[found] = value;
      make_most_recent(found, slot_age[found]);
      return ans;
    end
    if (mode == MODE_GET || limit_entries == 0) return ans;
    // A full store replaces its least recent entry in place.
    if (slot_count >= limit_entries) begin
      for (int i = 0; i < ENTRIES_DEF; i++) begin
        if (slot_valid[i] && slot_age[i] == slot_count - 1) victim = i;
      end
      if (victim >= 0) begin
        slot_key[victim]   = key;
        slot_value[victim] = value;
        make_most_recent(victim, slot_count - 1);
      end
      return ans;
    end
    // Otherwise the key goes into the first free slot.
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      if (!slot_valid[i]) begin
        slot_valid[i] = 1'b1;
        slot_key[i]   = key;
        slot_value[i] = value;
        make_most_recent(i, slot_count);
        slot_count++;
        break;
      end
    end
    return ans;
  endfunction

  // Track every transaction at the clock edge that accepts it.
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      empty_store();
      capacity_q = CAP_RESET;
      awaited_answers.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity_q = cfg_data;
        empty_store();
      end
      if (in_valid && in_ready) begin
        awaited_answers.push_back(cache_access(in_mode, in_key, in_write_value));
      end
      if (out_valid && out_ready) begin
        if (awaited_answers.size() == 0) begin
          $display("%0t: answer with none awaited: hit %0b read_value %h", $time, out_hit,
                   out_read_value);
          bad_answers++;
        end else begin
          want = awaited_answers.pop_front();
          if (out_hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_hit);
            bad_answers++;
          end
          if (out_read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                     out_read_value);
            bad_answers++;
          end
        end
      end
    end
    awaited = awaited_answers.size();
  end

endmodule

/* tb/sv/tb.sv */
// Top of the LRU key-value cache testbench: clock, reset, traffic and the verdict.
module tb import lruc_pkg::*; ();

  logic clk;
  logic rst_n;
  int   bad_answers;
  int   awaited;
  int   burst_left;
  int   stall_style;
  int   stall_cnt;

  lruc_in_if  #(.KEY_BITS(KEY_BITS_DEF), .VALUE_BITS(VALUE_BITS_DEF)) in_ch ();
  lruc_out_if #(.VALUE_BITS(VALUE_BITS_DEF)) out_ch ();
  lruc_cfg_if cfg_ch ();

  lru_key_value_cache_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lruc_answer_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_mode        (in_ch.mode),
    .in_key         (in_ch.key),
    .in_write_value (in_ch.write_value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_hit        (out_ch.hit),
    .out_read_value (out_ch.read_value),
    .cfg_valid      (cfg_ch.valid),
    .cfg_ready      (cfg_ch.ready),
    .cfg_data       (cfg_ch.data),
    .bad_answers    (bad_answers),
    .awaited        (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls in styles redrawn at random periodically.
  initial begin
    stall_style = 0;
    stall_cnt   = 0;
  end

  always @(posedge clk) begin
    stall_cnt++;
    if (stall_cnt % 256 == 0) stall_style = $urandom_range(0, 2);
    case (stall_style)
      0: begin
        out_ch.ready <= 1'b1;
      end
      1: begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ch.ready <= ((stall_cnt % 7) < 3);
      end
    endcase
  end

  // Offer one transaction, opening a new burst after a random gap when the last one ran out.
  task automatic send_access(input logic mode, input logic [KEY_BITS_DEF-1:0] key,
                             input logic [VALUE_BITS_DEF-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.key         <= key;
    in_ch.write_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  // Stop offering and wait until every awaited answer has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (awaited != 0);
    @(posedge clk);
  endtask

  // Write the capacity register once the block is idle.
  task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cap;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random traffic over a small pool of keys so that hits and evictions are frequent.
  task automatic random_phase(input logic [CAP_BITS-1:0] cap, input int n_items);
    logic [KEY_BITS_DEF-1:0] pool [24];
    int                      pool_size;
    int                      put_pct;
    logic                    mode;
    logic [KEY_BITS_DEF-1:0] key;
    write_capacity(cap);
    pool_size = ((cap > ENTRIES_DEF) ? ENTRIES_DEF : int'(cap)) + $urandom_range(1, 6);
    if (pool_size < 2) pool_size = 2;
    for (int i = 0; i < pool_size; i++) pool[i] = KEY_BITS_DEF'($urandom());
    put_pct = $urandom_range(30, 70);
    for (int n = 0; n < n_items; n++) begin
      mode = ($urandom_range(0, 99) < put_pct) ? MODE_PUT : MODE_GET;
      key  = ($urandom_range(0, 9) == 0) ? KEY_BITS_DEF'($urandom())
                                         : pool[$urandom_range(0, pool_size - 1)];
      send_access(mode, key, {$urandom(), $urandom()});
      if ($urandom_range(0, 149) == 0) drain();
    end
  endtask

  initial begin
    logic [CAP_BITS-1:0] caps [8];
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_GET;
    in_ch.key         = '0;
    in_ch.write_value = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    burst_left        = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, extreme keys and values, overwrite of a stored key.
    send_access(MODE_GET, '0, '0);
    send_access(MODE_PUT, '0, '0);
    send_access(MODE_PUT, '1, '1);
    send_access(MODE_GET, '1, '0);
    send_access(MODE_GET, '0, '1);
    send_access(MODE_PUT, '1, 64'h0123_4567_89ab_cdef);
    send_access(MODE_GET, '1, '0);
    send_access(MODE_GET, 31'h2aaa_aaaa, '0);

    // Directed: two entries, a get promotes its entry so the other one is evicted.
    write_capacity(5'd2);
    send_access(MODE_PUT, 31'd10, 64'ha);
    send_access(MODE_PUT, 31'd20, 64'hb);
    send_access(MODE_GET, 31'd10, '0);
    send_access(MODE_PUT, 31'd30, 64'hc);
    send_access(MODE_GET, 31'd20, '0);
    send_access(MODE_GET, 31'd10, '0);
    send_access(MODE_GET, 31'd30, '0);

    // Directed: capacity zero stores nothing.
    write_capacity(5'd0);
    send_access(MODE_PUT, 31'd5, '1);
    send_access(MODE_GET, 31'd5, '0);
    send_access(MODE_PUT, 31'd5, '0);

    // Random phases over several capacities, the extremes and saturation among them.
    caps = '{5'd1, 5'd31, 5'd3, 5'd0, 5'd17, 5'd16, 5'd8, 5'($urandom_range(0, 31))};
    foreach (caps[i]) random_phase(caps[i], 210);

    drain();
    repeat (20) @(posedge clk);
    if (bad_answers == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Run limit against a hung handshake.
  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end

endmodule
